[hdl/conv3_pkg.sv]
// conv3_pkg: constants, types and helpers for the 3x3 convolution stream
// no dependencies; imported by conv3x3_clamped_stream
package conv3_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);   // line store address
    localparam int WEFF_W    = COL_W + 1;           // width value up to MAX_WIDTH
    localparam int ROW_W     = 17;                  // row counter incl. drain row
    localparam int CNT_W     = 27;                  // output count within a frame
    localparam int TOTAL_W   = CNT_W + 1;

    localparam int PIX_W     = 8;
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 16;
    localparam int KROW_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam int PROD_W    = 17;                  // 9-bit signed pixel x 8-bit coef
    localparam int SUM_W     = 21;                  // nine products

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROW_TOP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROW_MID = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROW_BOT = 3'd4;

    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 16'd480;
    localparam logic [KROW_W-1:0]   RST_KERNEL_TOP   = 24'h0100FF;
    localparam logic [KROW_W-1:0]   RST_KERNEL_MID   = 24'h0200FE;
    localparam logic [KROW_W-1:0]   RST_KERNEL_BOT   = 24'h0100FF;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // per-item control decided when the item is taken
    typedef struct packed {
        logic emit;      // item produces a result
        logic last;      // that result closes the frame
        logic en_top;    // top kernel row inside the image
        logic en_bot;    // bottom kernel row inside the image
        logic en_left;   // left kernel column inside the image
        logic en_right;  // right kernel column inside the image
    } t_ctl;

    // signed coefficient of column j from a packed kernel row
    function automatic logic signed [PIX_W-1:0] coef(input logic [KROW_W-1:0] krow,
                                                     input logic [1:0] j);
        logic [PIX_W-1:0] b;
        b = krow[8*j +: 8];
        return signed'(b);
    endfunction

    // clamp a signed sum to 0..255
    function automatic logic [PIX_W-1:0] clamp255(input logic signed [SUM_W-1:0] v);
        logic [PIX_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > SUM_W'(PIX_MAX)) begin
            res = PIX_MAX;
        end else begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

[hdl/conv3x3_clamped_stream.sv]
// conv3x3_clamped_stream: streaming 3x3 signed convolution with zero borders and clamp
// uses conv3_pkg; holds two line memories, the 3x3 window and the frame counters
// the item that completes a window is registered in stage 1, its products in stage 2 and its result
//   in the output register; that item comes one row plus one pixel after the window centre
// throughput: one item per cycle while not stalled; the line memories are read once and written once per item
// reset (synchronous, active low): counters, window, pipeline valids and registers to defaults;
//   the line memories are not cleared, top rows are masked by the row counter instead
module conv3x3_clamped_stream (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [conv3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [conv3_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [conv3_pkg::PIX_W-1:0]        i_pixel_in,
    input  logic                               i_drain,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [conv3_pkg::PIX_W-1:0]        o_pixel_out,
    output logic                               o_frame_last
);
    import conv3_pkg::*;

    // configuration
    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic [KROW_W-1:0]   r_krow [3];

    // frame counters
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [CNT_W-1:0]    r_out_cnt;

    // line memories: mid holds the previous row, top the row before it
    logic [PIX_W-1:0]    r_mem_mid [MAX_WIDTH];
    logic [PIX_W-1:0]    r_mem_top [MAX_WIDTH];
    logic [PIX_W-1:0]    r_rd_mid;
    logic [PIX_W-1:0]    r_rd_top;
    logic                r_tw_pend;
    logic [COL_W-1:0]    r_tw_addr;

    // stage 1: item with its line memory data
    logic                r_s1_valid;
    logic [PIX_W-1:0]    r_s1_d;
    t_ctl                r_s1_ctl;
    logic [PIX_W-1:0]    r_win [3][3];

    // stage 2: products
    logic                       r_s2_valid;
    logic                       r_s2_last;
    logic signed [PROD_W-1:0]   r_s2_prod [3][3];

    // output register
    logic                r_out_valid;
    logic [PIX_W-1:0]    r_out_pixel;
    logic                r_out_last;

    // stage 0 signals
    logic                in_acc;
    logic [WEFF_W-1:0]   w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [TOTAL_W-1:0]  total;
    logic                emit_a;
    logic                emit_b;
    t_ctl                ctl0;
    logic [PIX_W-1:0]    pix_d;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    n_row;
    logic [CNT_W-1:0]    n_out_cnt;
    logic [WEFF_W-1:0]   col_inc;

    // pipeline moves
    logic                s1_adv;
    logic                s2_adv;
    logic                out_xfer;

    // stage 1 / 2 logic
    logic [PIX_W-1:0]           new_col [3];
    logic signed [PROD_W-1:0]   s1_prod [3][3];
    logic signed [SUM_W-1:0]    s2_sum;

    //------------------------------------------------------------------
    // handshake
    //------------------------------------------------------------------
    assign out_xfer   = r_out_valid && !i_out_stall;
    assign s2_adv     = r_s2_valid && (!r_out_valid || !i_out_stall);
    assign s1_adv     = r_s1_valid && (!r_s1_ctl.emit || !r_s2_valid || s2_adv);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_out_pixel;
    assign o_frame_last = r_out_last;

    //------------------------------------------------------------------
    // stage 0: frame geometry, borders and counters
    //------------------------------------------------------------------
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = WEFF_W'(1);
        end else if ({1'b0, r_image_width} > 13'(MAX_WIDTH)) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = r_image_width[WEFF_W-1:0];
        end
        h_eff = (r_image_height == '0) ? HEIGHT_W'(1) : r_image_height;
        total = TOTAL_W'(w_eff) * TOTAL_W'(h_eff);
        pix_d = i_drain ? '0 : i_pixel_in;
    end

    always_comb begin
        // column 0 closes the last pixel of row r-2, other columns pixel c-1 of row r-1
        emit_a = (r_col == '0) && (r_row >= ROW_W'(2));
        emit_b = (r_col != '0) && (r_row >= ROW_W'(1));
        ctl0.emit = emit_a || emit_b;
        ctl0.last = ({1'b0, r_out_cnt} + TOTAL_W'(1)) >= total;
        if (emit_a) begin
            ctl0.en_top   = (r_row != ROW_W'(2));
            ctl0.en_bot   = (r_row - ROW_W'(1)) < ROW_W'(h_eff);
            ctl0.en_left  = (w_eff != WEFF_W'(1));
            ctl0.en_right = 1'b0;
        end else begin
            ctl0.en_top   = (r_row != ROW_W'(1));
            ctl0.en_bot   = r_row < ROW_W'(h_eff);
            ctl0.en_left  = (r_col != COL_W'(1));
            ctl0.en_right = WEFF_W'(r_col) < w_eff;
        end
    end

    always_comb begin
        col_inc   = WEFF_W'(r_col) + WEFF_W'(1);
        n_col     = r_col;
        n_row     = r_row;
        n_out_cnt = r_out_cnt;
        if (ctl0.emit && ctl0.last) begin
            n_col     = '0;
            n_row     = '0;
            n_out_cnt = '0;
        end else begin
            if (ctl0.emit) begin
                n_out_cnt = r_out_cnt + CNT_W'(1);
            end
            if (col_inc >= w_eff) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    //------------------------------------------------------------------
    // configuration and control registers
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_krow[0]      <= RST_KERNEL_TOP;
            r_krow[1]      <= RST_KERNEL_MID;
            r_krow[2]      <= RST_KERNEL_BOT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:    r_image_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:   r_image_height <= i_cfg_data[HEIGHT_W-1:0];
                CFG_KERNEL_ROW_TOP: r_krow[0]      <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_ROW_MID: r_krow[1]      <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_ROW_BOT: r_krow[2]      <= i_cfg_data[KROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_out_cnt   <= '0;
            r_tw_pend   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            r_tw_pend <= in_acc;
            if (in_acc) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_out_cnt <= n_out_cnt;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && r_s1_ctl.emit) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            if (s1_adv) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                    r_win[i][2] <= new_col[i];
                end
            end
        end
    end

    //------------------------------------------------------------------
    // line memories
    //------------------------------------------------------------------
    // the top write happens in the cycle after its read, so a read of the same
    // column in that cycle takes the data on its way in
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_mid         <= r_mem_mid[r_col];
            r_mem_mid[r_col] <= pix_d;
            if (r_tw_pend && (r_tw_addr == r_col)) begin
                r_rd_top <= r_rd_mid;
            end else begin
                r_rd_top <= r_mem_top[r_col];
            end
            r_tw_addr <= r_col;
            r_s1_d    <= pix_d;
            r_s1_ctl  <= ctl0;
        end
        if (r_tw_pend) begin
            r_mem_top[r_tw_addr] <= r_rd_mid;
        end
    end

    //------------------------------------------------------------------
    // stage 1: window products
    //------------------------------------------------------------------
    always_comb begin
        logic [PIX_W-1:0] px;
        logic             en;
        new_col[0] = r_rd_top;
        new_col[1] = r_rd_mid;
        new_col[2] = r_s1_d;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (j == 0) begin
                    px = r_win[i][1];
                    en = r_s1_ctl.en_left;
                end else if (j == 1) begin
                    px = r_win[i][2];
                    en = 1'b1;
                end else begin
                    px = new_col[i];
                    en = r_s1_ctl.en_right;
                end
                if (i == 0) begin
                    en = en && r_s1_ctl.en_top;
                end else if (i == 2) begin
                    en = en && r_s1_ctl.en_bot;
                end
                if (en) begin
                    s1_prod[i][j] = PROD_W'(signed'({1'b0, px}))
                                    * PROD_W'(coef(r_krow[i], 2'(j)));
                end else begin
                    s1_prod[i][j] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_ctl.emit) begin
            r_s2_last <= r_s1_ctl.last;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_s2_prod[i][j] <= s1_prod[i][j];
                end
            end
        end
    end

    //------------------------------------------------------------------
    // stage 2: sum and clamp
    //------------------------------------------------------------------
    always_comb begin
        s2_sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s2_sum = s2_sum + SUM_W'(r_s2_prod[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out_pixel <= clamp255(s2_sum);
            r_out_last  <= r_s2_last;
        end
    end

`ifndef NO_ASSERTIONS
    // the closing result of a frame restarts the counters
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && ctl0.emit && ctl0.last |=>
            (r_col == '0) && (r_row == '0) && (r_out_cnt == '0))
        else $error("frame counters not restarted after last result");

    // otherwise the column steps by one or wraps to the next row
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !(ctl0.emit && ctl0.last) |=>
            (r_col == '0) || (r_col == $past(r_col) + COL_W'(1)))
        else $error("column counter skipped");

    // upstream is held back only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_s1_ctl.emit && r_s2_valid && r_out_valid
                       && i_out_stall)
        else $error("input stalled with room in the pipeline");

    // a held item keeps its line memory data
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv && !in_acc |=>
            (r_rd_mid === $past(r_rd_mid)) && (r_rd_top === $past(r_rd_top)))
        else $error("line data of a waiting item changed");
`endif

endmodule
